>>> src/tts_pkg.sv
package tts_pkg;

  localparam int TIME_W     = 32;
  localparam int INTERVAL_W = 31;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // scale of the squared term, as a shift
  localparam int SCALE_SHIFT = 8;

  localparam logic [TIME_W-1:0]     SCALE_ROUND    = 32'h0000_00ff;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 31'd5000000;

  // byte address of the report interval register
  localparam logic [APB_ADDR_W-1:0] ADDR_REPORT_INTERVAL = 3'd0;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_t;

  typedef enum logic {
    RES_REPORT = 1'b0,
    RES_UPTIME = 1'b1
  } res_kind_t;

endpackage

>>> src/tts_in_if.sv
interface tts_in_if;
  import tts_pkg::*;

  logic              valid;
  logic              ready;
  kind_t             kind;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] cur_time;

  modport source (output valid, output kind, output start_time, output cur_time,
                  input ready);
  modport sink (input valid, input kind, input start_time, input cur_time,
                output ready);
endinterface

>>> src/tts_out_if.sv
interface tts_out_if;
  import tts_pkg::*;

  logic              valid;
  logic              ready;
  res_kind_t         result_kind;
  logic [TIME_W-1:0] sample_count;
  logic [TIME_W-1:0] diff_sum;
  logic [TIME_W-1:0] diff_sumsq;
  logic [TIME_W-1:0] uptime_high;
  logic [TIME_W-1:0] uptime_low;

  modport source (output valid, output result_kind, output sample_count,
                  output diff_sum, output diff_sumsq, output uptime_high,
                  output uptime_low, input ready);
  modport sink (input valid, input result_kind, input sample_count,
                input diff_sum, input diff_sumsq, input uptime_high,
                input uptime_low, output ready);
endinterface

>>> src/task_timing_stats_accumulator_core.sv
// Task timing statistics. Each sample word (start and current timer value)
// adds its duration to a sample count, a wrapping sum and a saturating sum of
// scaled, rounded-up squares; once the current time is report_interval ticks
// past the last report (signed wrap compare) the three totals are sent out in
// a report word and cleared, and the wrap epoch advances if the timer wrapped.
// An uptime query returns {epoch, +1 if the timer wrapped since the last report,
// current time} and changes nothing; samples short of the report time give no
// result. An accepted word is held in the input register, then makes one pass
// of a 16x20 multiplier, add and saturate into the accumulators and the result
// register. A word is taken every cycle; the input stalls only while a result
// waits untaken in the result register. The user must write report_interval
// (APB port, byte address 0) only while idle; the block does not enforce it.
module task_timing_stats_accumulator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  tts_in_if.sink                             in_ch,
  tts_out_if.source                          out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [tts_pkg::APB_ADDR_W-1:0]     cfg_paddr,
  input  logic [tts_pkg::APB_DATA_W-1:0]     cfg_pwdata,
  output logic [tts_pkg::APB_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);
  import tts_pkg::*;

  localparam int PROD_W = 36;

  logic [INTERVAL_W-1:0] report_interval_r;

  logic              s1_valid_r;
  kind_t             s1_kind_r;
  logic [TIME_W-1:0] s1_start_r;
  logic [TIME_W-1:0] s1_cur_r;

  logic [TIME_W-1:0] acc_count_r, acc_count_nxt;
  logic [TIME_W-1:0] acc_sum_r, acc_sum_nxt;
  logic [TIME_W-1:0] acc_sumsq_r, acc_sumsq_nxt;
  logic [TIME_W-1:0] last_report_r, last_report_nxt;
  logic [TIME_W-1:0] wrap_epoch_r, wrap_epoch_nxt;

  logic              out_valid_r;
  res_kind_t         out_kind_r;
  logic [TIME_W-1:0] out_count_r, out_sum_r, out_sumsq_r, out_up_hi_r, out_up_lo_r;

  logic              cfg_wr;
  logic              in_fire;
  logic              s1_emit, s1_fire, out_free;
  logic [TIME_W-1:0] diff, gap, cnt_new, sum_new, sumsq_new;
  logic              is_small, is_mid, due, wrapped;
  logic [12:0]       ceil_div;
  logic [15:0]       mul_a;
  logic [19:0]       mul_b;
  logic [PROD_W-1:0] prod, rounded, term;
  logic [PROD_W:0]   total;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr == ADDR_REPORT_INTERVAL);
  assign cfg_prdata = (cfg_paddr == ADDR_REPORT_INTERVAL)
                      ? {1'b0, report_interval_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_interval_r <= INTERVAL_RESET;
    end else if (cfg_wr) begin
      report_interval_r <= cfg_pwdata[INTERVAL_W-1:0];
    end
  end

  // duration and squared term
  always_comb begin
    diff     = s1_cur_r - s1_start_r;
    is_small = (diff[31:16] == '0);
    is_mid   = (diff[31:20] == '0);
    ceil_div = {1'b0, diff[19:8]} + 13'(|diff[7:0]);
    mul_a    = is_small ? diff[15:0] : {3'b000, ceil_div};
    mul_b    = diff[19:0];
    prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
    rounded  = (prod + PROD_W'(SCALE_ROUND)) >> SCALE_SHIFT;
    term     = is_small ? rounded : prod;
    total    = {1'b0, 4'b0000, acc_sumsq_r} + {1'b0, term};
    sumsq_new = (!is_mid || (total[PROD_W:TIME_W] != '0)) ? '1 : total[TIME_W-1:0];
    cnt_new  = acc_count_r + 32'd1;
    sum_new  = acc_sum_r + diff;
    gap      = s1_cur_r - (last_report_r + {1'b0, report_interval_r});
    due      = !gap[TIME_W-1];
    wrapped  = (s1_cur_r < last_report_r);
  end

  // handshake: samples that give no result never wait on the output side
  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_emit      = (s1_kind_r == KIND_QUERY) || due;
  assign s1_fire      = s1_valid_r && (!s1_emit || out_free);
  assign in_ch.ready  = !s1_valid_r || s1_fire;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r  <= in_ch.kind;
      s1_start_r <= in_ch.start_time;
      s1_cur_r   <= in_ch.cur_time;
    end
  end

  always_comb begin
    acc_count_nxt   = acc_count_r;
    acc_sum_nxt     = acc_sum_r;
    acc_sumsq_nxt   = acc_sumsq_r;
    last_report_nxt = last_report_r;
    wrap_epoch_nxt  = wrap_epoch_r;
    if (s1_fire && (s1_kind_r == KIND_SAMPLE)) begin
      if (due) begin
        acc_count_nxt   = '0;
        acc_sum_nxt     = '0;
        acc_sumsq_nxt   = '0;
        last_report_nxt = s1_cur_r;
        wrap_epoch_nxt  = wrap_epoch_r + TIME_W'(wrapped);
      end else begin
        acc_count_nxt = cnt_new;
        acc_sum_nxt   = sum_new;
        acc_sumsq_nxt = sumsq_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_count_r   <= '0;
      acc_sum_r     <= '0;
      acc_sumsq_r   <= '0;
      last_report_r <= '0;
      wrap_epoch_r  <= '0;
    end else begin
      acc_count_r   <= acc_count_nxt;
      acc_sum_r     <= acc_sum_nxt;
      acc_sumsq_r   <= acc_sumsq_nxt;
      last_report_r <= last_report_nxt;
      wrap_epoch_r  <= wrap_epoch_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit) begin
      if (s1_kind_r == KIND_QUERY) begin
        out_kind_r  <= RES_UPTIME;
        out_count_r <= '0;
        out_sum_r   <= '0;
        out_sumsq_r <= '0;
        out_up_hi_r <= wrap_epoch_r + TIME_W'(wrapped);
        out_up_lo_r <= s1_cur_r;
      end else begin
        out_kind_r  <= RES_REPORT;
        out_count_r <= cnt_new;
        out_sum_r   <= sum_new;
        out_sumsq_r <= sumsq_new;
        out_up_hi_r <= '0;
        out_up_lo_r <= '0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = out_kind_r;
  assign out_ch.sample_count = out_count_r;
  assign out_ch.diff_sum     = out_sum_r;
  assign out_ch.diff_sumsq   = out_sumsq_r;
  assign out_ch.uptime_high  = out_up_hi_r;
  assign out_ch.uptime_low   = out_up_lo_r;

endmodule

>>> tb/sv/task_timing_stats_accumulator_core_tb.sv
module task_timing_stats_accumulator_core_tb;
  import tts_pkg::*;

  localparam logic [TIME_W-1:0] SMALL_SPAN  = 32'h0000_ffff;
  localparam logic [TIME_W-1:0] MID_SPAN    = 32'h000f_ffff;
  localparam logic [TIME_W-1:0] ALL_ONES    = 32'hffff_ffff;
  localparam logic [TIME_W-1:0] SIGN_BIT    = 32'h8000_0000;
  localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = 31'h7fff_ffff;
  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD   = 60;
  localparam int SETTLE      = 4;

  typedef struct packed {
    res_kind_t         kind;
    logic [TIME_W-1:0] count;
    logic [TIME_W-1:0] total;
    logic [TIME_W-1:0] sq_total;
    logic [TIME_W-1:0] up_high;
    logic [TIME_W-1:0] up_low;
  } stats_word_t;

  class timing_stats_scoreboard;
    logic [INTERVAL_W-1:0] interval;
    logic [TIME_W-1:0]     n_samples;
    logic [TIME_W-1:0]     dur_total;
    logic [TIME_W-1:0]     sq_total;
    logic [TIME_W-1:0]     last_report;
    logic [TIME_W-1:0]     epoch;
    stats_word_t           expected_words[$];
    int                    mismatches;

    function new();
      interval    = INTERVAL_RESET;
      n_samples   = '0;
      dur_total   = '0;
      sq_total    = '0;
      last_report = '0;
      epoch       = '0;
      mismatches  = 0;
    endfunction

    function void set_interval(logic [INTERVAL_W-1:0] value);
      interval = value;
    endfunction

    // scaled square, rounded up, added with saturation
    function logic [TIME_W-1:0] sumsq_after(logic [TIME_W-1:0] acc, logic [TIME_W-1:0] dur);
      logic [63:0] term;
      logic [63:0] sum;
      if (dur <= SMALL_SPAN) begin
        term = ({32'b0, dur} * {32'b0, dur} + {32'b0, SCALE_ROUND}) >> SCALE_SHIFT;
      end else if (dur <= MID_SPAN) begin
        term = (({32'b0, dur} + {32'b0, SCALE_ROUND}) >> SCALE_SHIFT) * {32'b0, dur};
      end else begin
        return ALL_ONES;
      end
      sum = {32'b0, acc} + term;
      if (sum > {32'b0, ALL_ONES}) return ALL_ONES;
      return sum[TIME_W-1:0];
    endfunction

    function void note_word(kind_t kind, logic [TIME_W-1:0] start_t, logic [TIME_W-1:0] cur_t);
      stats_word_t       w;
      logic [TIME_W-1:0] dur;
      logic [TIME_W-1:0] gap;
      w = '0;
      if (kind == KIND_QUERY) begin
        w.kind    = RES_UPTIME;
        w.up_high = epoch + ((cur_t < last_report) ? 32'd1 : 32'd0);
        w.up_low  = cur_t;
        expected_words.push_back(w);
        return;
      end
      dur       = cur_t - start_t;
      n_samples = n_samples + 32'd1;
      dur_total = dur_total + dur;
      sq_total  = sumsq_after(sq_total, dur);
      gap = cur_t - (last_report + {1'b0, interval});
      if ((gap & SIGN_BIT) != '0) return;
      w.kind     = RES_REPORT;
      w.count    = n_samples;
      w.total    = dur_total;
      w.sq_total = sq_total;
      expected_words.push_back(w);
      if (cur_t < last_report) epoch = epoch + 32'd1;
      last_report = cur_t;
      n_samples   = '0;
      dur_total   = '0;
      sq_total    = '0;
    endfunction

    task mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
      if (got !== want) mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task check_word(stats_word_t got);
      stats_word_t want;
      if (expected_words.size() == 0) begin
        mismatch("result word with nothing expected");
        return;
      end
      want = expected_words.pop_front();
      compare_field("result_kind", {31'b0, got.kind}, {31'b0, want.kind});
      compare_field("sample_count", got.count, want.count);
      compare_field("diff_sum", got.total, want.total);
      compare_field("diff_sumsq", got.sq_total, want.sq_total);
      compare_field("uptime_high", got.up_high, want.up_high);
      compare_field("uptime_low", got.up_low, want.up_low);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [APB_ADDR_W-1:0] cfg_paddr;
  logic [APB_DATA_W-1:0] cfg_pwdata;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int stall_pct = 0;
  int hold_reqs = 0;
  logic [TIME_W-1:0] tick_now;

  timing_stats_scoreboard sb = new();

  tts_in_if  in_ch ();
  tts_out_if out_ch ();

  task_timing_stats_accumulator_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // result side: random stalls plus an occasional long hold
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    stats_word_t got;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.kind     = out_ch.result_kind;
      got.count    = out_ch.sample_count;
      got.total    = out_ch.diff_sum;
      got.sq_total = out_ch.diff_sumsq;
      got.up_high  = out_ch.uptime_high;
      got.up_low   = out_ch.uptime_low;
      sb.check_word(got);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  task send_word(kind_t kind, logic [TIME_W-1:0] start_t, logic [TIME_W-1:0] cur_t,
                 int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.start_time <= start_t;
    in_ch.cur_time   <= cur_t;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_word(kind, start_t, cur_t);
  endtask

  task pause_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_words.size() != 0);
  endtask

  task write_interval(logic [INTERVAL_W-1:0] value);
    pause_until_drained();
    // a sample with no report may still be in flight
    repeat (SETTLE) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_REPORT_INTERVAL;
    cfg_pwdata  <= {1'b0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_interval(value);
  endtask

  function automatic logic [TIME_W-1:0] pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return $urandom_range(0, 300);
    if (r < 85) return $urandom_range(0, SMALL_SPAN);
    if (r < 95) return $urandom_range(SMALL_SPAN + 1, MID_SPAN);
    return $urandom();
  endfunction

  task random_word(logic [TIME_W-1:0] span, int idle_pct);
    int r;
    logic [TIME_W-1:0] dur;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      if (r < 3) send_word(KIND_QUERY, $urandom(), $urandom(), idle_pct);
      else send_word(KIND_QUERY, $urandom(), tick_now + $urandom_range(0, span), idle_pct);
    end else if (r < 22) begin
      // noise: unrelated timer values
      send_word(KIND_SAMPLE, $urandom(), $urandom(), idle_pct);
    end else begin
      tick_now = tick_now + $urandom_range(0, span);
      dur = pick_duration();
      send_word(KIND_SAMPLE, tick_now - dur, tick_now, idle_pct);
    end
  endtask

  task run_phase(int n_words, int send_idle, int recv_idle, logic [INTERVAL_W-1:0] iv,
                 bit pressure);
    logic [TIME_W-1:0] span;
    write_interval(iv);
    stall_pct <= recv_idle;
    span = {1'b0, iv} / 3 + 32'd8;
    for (int i = 0; i < n_words; i++) begin
      if (pressure && i == 20) hold_reqs <= hold_reqs + 1;
      if (pressure && i == 90) pause_until_drained();
      random_word(span, send_idle);
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_SAMPLE;
    in_ch.start_time <= '0;
    in_ch.cur_time   <= '0;
    cfg_psel         <= 1'b0;
    cfg_penable      <= 1'b0;
    cfg_pwrite       <= 1'b0;
    cfg_paddr        <= '0;
    cfg_pwdata       <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset interval: duration bands, saturation, exact due time, timer wrap
    send_word(KIND_QUERY, ALL_ONES, 32'd0, 0);
    send_word(KIND_SAMPLE, 32'd0, 32'd0, 0);
    send_word(KIND_SAMPLE, 32'd100 - SMALL_SPAN, 32'd100, 0);
    send_word(KIND_SAMPLE, 32'd200 - (SMALL_SPAN + 1), 32'd200, 0);
    send_word(KIND_SAMPLE, 32'd300 - MID_SPAN, 32'd300, 0);
    send_word(KIND_SAMPLE, 32'd400 - MID_SPAN, 32'd400, 0);
    send_word(KIND_QUERY, 32'd0, ALL_ONES, 0);
    send_word(KIND_SAMPLE, 32'd4999999, 32'd4999999, 0);
    send_word(KIND_SAMPLE, 32'd5000000 - (MID_SPAN + 1), 32'd5000000, 0);
    send_word(KIND_QUERY, 32'd0, 32'd0, 0);
    send_word(KIND_SAMPLE, 32'd0, ALL_ONES, 0);
    send_word(KIND_SAMPLE, 32'h7fff_f000, 32'h7fff_ffff, 0);
    send_word(KIND_SAMPLE, 32'h0000_0f00, 32'h0000_1000, 0);
    send_word(KIND_QUERY, 32'd0, ALL_ONES, 0);
    send_word(KIND_SAMPLE, SIGN_BIT, SIGN_BIT, 0);

    // zero interval: due exactly at the last report time, not one tick early
    write_interval('0);
    send_word(KIND_SAMPLE, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    send_word(KIND_SAMPLE, SIGN_BIT, SIGN_BIT, 0);
    send_word(KIND_SAMPLE, 32'd0, 32'd0, 0);
    send_word(KIND_SAMPLE, 32'd1, 32'd1, 0);
    send_word(KIND_SAMPLE, SIGN_BIT - 32'd5, SIGN_BIT, 0);

    tick_now = SIGN_BIT;
    run_phase(125, 0, 0, '0, 1'b1);
    run_phase(125, 62, 0, 31'd1000, 1'b0);
    run_phase(125, 0, 62, INTERVAL_MAX, 1'b0);
    run_phase(125, 32, 32, INTERVAL_W'($urandom_range(1, 100000)), 1'b0);

    pause_until_drained();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> task_timing_stats_accumulator_core.f
src/tts_pkg.sv
src/tts_in_if.sv
src/tts_out_if.sv
src/task_timing_stats_accumulator_core.sv
tb/sv/task_timing_stats_accumulator_core_tb.sv
